// ===== src/button_debounce_press_classifier_defines.svh =====
// Assertion macros for the top RTL file of the button debouncer.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BDPC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdpc: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define BDPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bdpc: next-cycle check failed");

`endif

// ===== src/bdpc_pkg.sv =====
package bdpc_pkg;

  localparam int unsigned CFG_WIDTH = 16;
  localparam int unsigned CFG_INDEX_WIDTH = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLICK      = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BIG_PRESS  = 3'd4;

  // Reset values of the registers
  localparam logic                 ENABLE_RESET     = 1'b1;
  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CFG_WIDTH-1:0] CLICK_RESET      = 16'd300;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] BIG_PRESS_RESET  = 16'd5000;

  typedef struct packed {
    logic                 enable;
    logic [CFG_WIDTH-1:0] debounce_ms;
    logic [CFG_WIDTH-1:0] click_ms;
    logic [CFG_WIDTH-1:0] long_press_ms;
    logic [CFG_WIDTH-1:0] big_press_ms;
  } cfg_t;

  // Result of one tick, packed lowest bit first as level
  typedef struct packed {
    logic big_press;
    logic long_press;
    logic click;
    logic changed;
    logic level;
  } result_t;

endpackage

// ===== src/bdpc_core.sv =====
module bdpc_core #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              pressed,
  input  bdpc_pkg::cfg_t    cfg,
  output bdpc_pkg::result_t result
);

  localparam int unsigned CMP_WIDTH =
    (TIMER_WIDTH > bdpc_pkg::CFG_WIDTH) ? TIMER_WIDTH : bdpc_pkg::CFG_WIDTH;

  logic                   last_sample;
  logic                   last_sample_next;
  logic                   stable_level;
  logic                   stable_level_next;
  logic [TIMER_WIDTH-1:0] since_change;
  logic [TIMER_WIDTH-1:0] since_change_next;
  logic [TIMER_WIDTH-1:0] since_toggle;
  logic [TIMER_WIDTH-1:0] since_toggle_next;

  logic [TIMER_WIDTH-1:0] toggle_inc;
  logic [TIMER_WIDTH-1:0] change_inc;
  logic [CMP_WIDTH-1:0]   change_ext;
  logic [CMP_WIDTH-1:0]   interval_ext;
  logic                   accept_level;

  // Saturating increments of both timers
  assign toggle_inc = (&since_toggle) ? since_toggle : since_toggle + 1'b1;
  assign change_inc = (&since_change) ? since_change : since_change + 1'b1;

  // Decide the tick: restart the raw timer, test for a debounced toggle
  always_comb begin
    last_sample_next  = last_sample;
    stable_level_next = stable_level;
    since_change_next = since_change;
    since_toggle_next = since_toggle;
    result            = '0;
    change_ext        = '0;
    interval_ext      = CMP_WIDTH'(toggle_inc);
    accept_level      = 1'b0;
    if (cfg.enable) begin
      since_toggle_next = toggle_inc;
      if (pressed != last_sample) begin
        last_sample_next  = pressed;
        since_change_next = '0;
      end else begin
        since_change_next = change_inc;
      end
      change_ext   = CMP_WIDTH'(since_change_next);
      accept_level = (change_ext >= CMP_WIDTH'(cfg.debounce_ms)) &&
                     (pressed != stable_level);
      if (accept_level) begin
        stable_level_next = pressed;
        since_toggle_next = '0;
        result.changed    = 1'b1;
        result.click      = interval_ext < CMP_WIDTH'(cfg.click_ms);
        if (!pressed) begin
          if (interval_ext > CMP_WIDTH'(cfg.big_press_ms)) begin
            result.big_press = 1'b1;
          end else if (interval_ext > CMP_WIDTH'(cfg.long_press_ms)) begin
            result.long_press = 1'b1;
          end
        end
      end
    end
    result.level = stable_level_next;
  end

  // Advance the state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample  <= 1'b0;
      stable_level <= 1'b0;
      since_change <= '0;
      since_toggle <= '0;
    end else if (step) begin
      last_sample  <= last_sample_next;
      stable_level <= stable_level_next;
      since_change <= since_change_next;
      since_toggle <= since_toggle_next;
    end
  end

endmodule

// ===== src/button_debounce_press_classifier.sv =====
// Button debouncer with click, long-press and big-press classification.
// Each transaction on the s_axis channel is one millisecond tick carrying the
// sampled button level in s_axis_tdata[0]. Every accepted tick produces exactly
// one m_axis transaction: the debounced level, a toggle flag, and the click,
// long-press and big-press flags for that tick.
// Results are registered in the output stage; one tick is accepted every cycle
// while s_axis_tready is high, with timer update and compare combinational.
// A two-entry output stage (result register plus skid register) lets a tick
// be taken while one result waits; s_axis_tready drops only when both are
// full, and results are held unchanged while m_axis_tready is low.
// The user must write registers via cfg_we/cfg_index/cfg_data only while idle;
// the block does not enforce it. Indexes: 0 enable, 1 debounce_ms, 2 click_ms,
// 3 long_press_ms, 4 big_press_ms. Synchronous rst restores register defaults
// (1, 50, 300, 1000, 5000), sets raw and debounced levels to released, clears
// both timers, empties the output stage. Timers saturate at 2^TIMER_WIDTH - 1.
`include "button_debounce_press_classifier_defines.svh"

module button_debounce_press_classifier #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,  // [0] pressed
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] level, [1] changed, [2] click, [3] long_press, [4] big_press
  output logic [7:0]                           m_axis_tdata,
  input  logic                                 cfg_we,
  input  logic [bdpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [bdpc_pkg::CFG_WIDTH-1:0]       cfg_data
);

  bdpc_pkg::cfg_t    cfg;
  bdpc_pkg::result_t new_result;
  bdpc_pkg::result_t out_data;
  bdpc_pkg::result_t skid_data;
  logic              out_valid;
  logic              skid_valid;
  logic              accept;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable        <= bdpc_pkg::ENABLE_RESET;
      cfg.debounce_ms   <= bdpc_pkg::DEBOUNCE_RESET;
      cfg.click_ms      <= bdpc_pkg::CLICK_RESET;
      cfg.long_press_ms <= bdpc_pkg::LONG_PRESS_RESET;
      cfg.big_press_ms  <= bdpc_pkg::BIG_PRESS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bdpc_pkg::REG_ENABLE:     cfg.enable        <= cfg_data[0];
        bdpc_pkg::REG_DEBOUNCE:   cfg.debounce_ms   <= cfg_data;
        bdpc_pkg::REG_CLICK:      cfg.click_ms      <= cfg_data;
        bdpc_pkg::REG_LONG_PRESS: cfg.long_press_ms <= cfg_data;
        bdpc_pkg::REG_BIG_PRESS:  cfg.big_press_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  bdpc_core #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .pressed(s_axis_tdata[0]),
    .cfg    (cfg),
    .result (new_result)
  );

  // Valid flags of the output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Result payload: refill from skid first, else take the new tick
  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      out_data <= skid_valid ? skid_data : new_result;
    end else if (accept) begin
      skid_data <= new_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_data};

  `BDPC_ASSERT_NOW(a_skid_needs_out, clk, rst, skid_valid, out_valid)
  `BDPC_ASSERT_NEXT(a_stall_fills_skid, clk, rst,
    accept && out_valid && !m_axis_tready, skid_valid && out_valid)
  `BDPC_ASSERT_NOW(a_press_on_release, clk, rst,
    out_valid && (out_data.long_press || out_data.big_press),
    out_data.changed && !out_data.level)
  `BDPC_ASSERT_NOW(a_press_exclusive, clk, rst,
    out_valid, !(out_data.long_press && out_data.big_press))
  `BDPC_ASSERT_NOW(a_click_on_toggle, clk, rst,
    out_valid && out_data.click, out_data.changed)

endmodule

// ===== dv/press_classifier_checker.sv =====
`timescale 1ns / 100ps

// Watches the tick, result and register channels of the debouncer, predicts
// every result from its own copy of the state and compares in order.
module press_classifier_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bdpc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [bdpc_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  logic                                 tick_valid,
  input  logic                                 tick_ready,
  input  logic [7:0]                           tick_data,   // [0] pressed
  input  logic                                 res_valid,
  input  logic                                 res_ready,
  // [0] level, [1] changed, [2] click, [3] long_press, [4] big_press
  input  logic [7:0]                           res_data,
  input  logic                                 drain,
  output int unsigned                          pending,
  output int unsigned                          errors
);
  import bdpc_pkg::*;

  localparam logic [15:0] TIMER_TOP = 16'hFFFF;
  localparam int unsigned PRINT_CAP = 30;

  // Predicted block state and register copy
  cfg_t        settings;
  logic        last_sample;
  logic        debounced;
  logic [15:0] since_change;
  logic [15:0] since_toggle;

  result_t     expected_ticks[$];
  int unsigned results_seen;
  int unsigned toggles_seen;
  int unsigned clicks_seen;
  int unsigned longs_seen;
  int unsigned bigs_seen;
  bit          drained;

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic flag_mismatch(input string what);
    if (errors < PRINT_CAP) $display("%0t ns: mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic compare_flag(input string name, input logic got, input logic want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s got %b want %b", results_seen, name, got, want));
  endtask

  // Count up and hold at the top instead of wrapping
  function automatic logic [15:0] bump(input logic [15:0] t);
    return (t == TIMER_TOP) ? t : t + 16'd1;
  endfunction

  // Advance the debouncer by one millisecond tick and classify any toggle
  function automatic result_t classify_tick(input logic pressed);
    result_t     r;
    logic [15:0] span;
    r = '0;
    if (settings.enable) begin
      since_toggle = bump(since_toggle);
      if (pressed != last_sample) begin
        last_sample  = pressed;
        since_change = '0;
      end else begin
        since_change = bump(since_change);
      end
      if (since_change >= settings.debounce_ms && pressed != debounced) begin
        span         = since_toggle;
        debounced    = pressed;
        since_toggle = '0;
        r.changed    = 1'b1;
        r.click      = (span < settings.click_ms);
        // only a release is graded by hold time
        if (!debounced) begin
          if (span > settings.big_press_ms) r.big_press = 1'b1;
          else if (span > settings.long_press_ms) r.long_press = 1'b1;
        end
      end
    end
    r.level = debounced;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      settings     = '{enable: ENABLE_RESET, debounce_ms: DEBOUNCE_RESET,
                       click_ms: CLICK_RESET, long_press_ms: LONG_PRESS_RESET,
                       big_press_ms: BIG_PRESS_RESET};
      last_sample  = 1'b0;
      debounced    = 1'b0;
      since_change = '0;
      since_toggle = '0;
      expected_ticks.delete();
      results_seen = 0;
      toggles_seen = 0;
      clicks_seen  = 0;
      longs_seen   = 0;
      bigs_seen    = 0;
      drained      = 1'b0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE:     settings.enable        = cfg_data[0];
          REG_DEBOUNCE:   settings.debounce_ms   = cfg_data;
          REG_CLICK:      settings.click_ms      = cfg_data;
          REG_LONG_PRESS: settings.long_press_ms = cfg_data;
          REG_BIG_PRESS:  settings.big_press_ms  = cfg_data;
          default: ;
        endcase
      end

      // Predict one result per accepted tick
      if (tick_valid && tick_ready) begin
        want = classify_tick(tick_data[0]);
        toggles_seen += want.changed;
        clicks_seen  += want.click;
        longs_seen   += want.long_press;
        bigs_seen    += want.big_press;
        expected_ticks.push_back(want);
      end

      // Compare each result transaction against the oldest prediction
      if (res_valid && res_ready) begin
        if (expected_ticks.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with no tick pending", results_seen));
        end else begin
          want = expected_ticks.pop_front();
          got  = result_t'(res_data[4:0]);
          compare_flag("level", got.level, want.level);
          compare_flag("changed", got.changed, want.changed);
          compare_flag("click", got.click, want.click);
          compare_flag("long_press", got.long_press, want.long_press);
          compare_flag("big_press", got.big_press, want.big_press);
          if (res_data[7:5] !== 3'b000)
            flag_mismatch($sformatf("result %0d pad bits %b", results_seen, res_data[7:5]));
        end
        results_seen++;
      end

      // Drop whatever never arrived and summarize once
      if (drain && !drained) begin
        while (expected_ticks.size() != 0) begin
          want = expected_ticks.pop_front();
          flag_mismatch($sformatf("result for tick %0d never arrived", results_seen));
          results_seen++;
        end
        $display("checked %0d tick results: %0d toggles, %0d clicks, %0d long, %0d big presses",
                 results_seen, toggles_seen, clicks_seen, longs_seen, bigs_seen);
        $display("register sets included zero and full-scale thresholds and a disabled block");
        drained = 1'b1;
      end
      pending = expected_ticks.size();
    end
  end

endmodule

// ===== dv/button_debounce_press_classifier_tb.sv =====
`timescale 1ns / 100ps

module button_debounce_press_classifier_tb;
  import bdpc_pkg::*;

  localparam logic [15:0] FULL_SCALE = 16'hFFFF;
  localparam int unsigned SQUEEZE_CYCLES = 80;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [7:0]                 s_axis_tdata = 8'd0;   // [0] pressed
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  // [0] level, [1] changed, [2] click, [3] long_press, [4] big_press
  logic [7:0]                 m_axis_tdata;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_ENABLE;
  logic [CFG_WIDTH-1:0]       cfg_data = '0;
  logic                       drain = 1'b0;
  int unsigned                pending;
  int unsigned                errors;

  bit   jitter = 1'b1;
  bit   squeeze_pending = 1'b0;
  logic button = 1'b0;

  always #1 clk = ~clk;

  button_debounce_press_classifier uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  press_classifier_checker u_checker (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .tick_valid(s_axis_tvalid),
    .tick_ready(s_axis_tready),
    .tick_data(s_axis_tdata),
    .res_valid(m_axis_tvalid),
    .res_ready(m_axis_tready),
    .res_data(m_axis_tdata),
    .drain(drain),
    .pending(pending),
    .errors(errors)
  );

  // Offer one tick and hold it until the transaction completes
  task automatic send_tick(input logic p);
    if (jitter && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, p};
    button = p;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_level(input logic p, input int unsigned n);
    repeat (n) send_tick(p);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_config(input logic en, input logic [15:0] deb, input logic [15:0] clk_t,
                             input logic [15:0] lng, input logic [15:0] big);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ENABLE;
    cfg_data  <= {15'd0, en};
    @(posedge clk);
    cfg_index <= REG_DEBOUNCE;
    cfg_data  <= deb;
    @(posedge clk);
    cfg_index <= REG_CLICK;
    cfg_data  <= clk_t;
    @(posedge clk);
    cfg_index <= REG_LONG_PRESS;
    cfg_data  <= lng;
    @(posedge clk);
    cfg_index <= REG_BIG_PRESS;
    cfg_data  <= big;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly small thresholds, with the extremes now and then
  function automatic logic [15:0] pick_limit(input int unsigned span);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return FULL_SCALE;
      default: return 16'($urandom_range(1, span));
    endcase
  endfunction

  // Press/release sequences: bounce, then a hold around the thresholds,
  // with some raw noise mixed in
  task automatic run_presses(input int unsigned n, input logic [15:0] deb,
                             input logic [15:0] clk_t, input logic [15:0] lng,
                             input logic [15:0] big);
    int unsigned sent;
    int unsigned hold;
    int unsigned bounce;
    int unsigned d_c, c_c, l_c, b_c;
    d_c  = (deb > 60) ? 60 : deb;
    c_c  = (clk_t > 60) ? 60 : clk_t;
    l_c  = (lng > 60) ? 60 : lng;
    b_c  = (big > 60) ? 60 : big;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 5) == 0) begin
        bounce = $urandom_range(1, 4);
        repeat (bounce) send_tick(1'($urandom_range(0, 1)));
        sent += bounce;
      end else begin
        bounce = $urandom_range(0, 3);
        repeat (bounce) send_tick(~button);
        case ($urandom_range(0, 3))
          0: hold = $urandom_range(0, c_c + 1);
          1: hold = $urandom_range(l_c, l_c + 3);
          2: hold = $urandom_range(b_c, b_c + 3);
          default: hold = $urandom_range(0, 3);
        endcase
        hold += d_c + 1;
        send_level(~button, hold);
        sent += bounce + hold;
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      if (squeeze_pending) begin
        squeeze_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else if (jitter && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic        en;
    logic [15:0] deb, clk_t, lng, big;
    int unsigned guard;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero debounce, click on each press, long and big release
    load_config(1'b1, 16'd0, 16'd3, 16'd4, 16'd7);
    send_level(1'b1, 6);
    send_level(1'b0, 1);
    send_level(1'b1, 9);
    send_level(1'b0, 2);

    // Disabled block holds its state
    load_config(1'b0, 16'd0, 16'd3, 16'd4, 16'd7);
    send_level(1'b1, 2);
    send_level(1'b0, 1);
    load_config(1'b1, 16'd2, 16'd3, 16'd4, 16'd7);
    send_level(1'b1, 3);

    // Random phases; the last ones run without idling
    for (int phase = 0; phase < 12; phase++) begin
      jitter = (phase < 9);
      en     = 1'b1;
      deb    = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
      clk_t  = pick_limit(30);
      lng    = pick_limit(40);
      big    = pick_limit(60);
      if (phase == 1) begin
        clk_t = FULL_SCALE;
        lng   = '0;
        big   = '0;
      end
      if (phase == 4) begin
        deb   = '0;
        clk_t = '0;
        lng   = FULL_SCALE;
        big   = FULL_SCALE;
      end
      if (phase == 6) en = 1'b0;
      load_config(en, deb, clk_t, lng, big);
      if (phase == 2) squeeze_pending = 1'b1;
      run_presses((phase == 6) ? 40 : 130, deb, clk_t, lng, big);
    end

    // Drain and let any stray result show up
    s_axis_tvalid <= 1'b0;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < 2000);
    repeat (5) @(posedge clk);
    drain <= 1'b1;
    repeat (2) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== button_debounce_press_classifier.f =====
+incdir+src
src/bdpc_pkg.sv
src/bdpc_core.sv
src/button_debounce_press_classifier.sv
dv/press_classifier_checker.sv
dv/button_debounce_press_classifier_tb.sv
